@@ src/albs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the additive LFSR byte scrambler.
// Holds widths, register indexes and the feedback helper; no dependencies.
package albs_pkg;

  localparam int DATA_W    = 8;
  localparam int LFSR_W    = 32;
  localparam int POS_W     = 5;
  localparam int BPB_W     = 4;
  localparam int CNT_W     = 24;
  localparam int ADDR_W    = 5;
  localparam int APB_W     = 32;
  localparam int IDX_W     = 3;
  localparam int MAX_STEPS = 8;

  localparam logic [CNT_W-1:0] COUNTER_MAX = {CNT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_FEEDBACK_MASK   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SEED_VALUE      = 3'd1;
  localparam logic [IDX_W-1:0] REG_INSERT_POSITION = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAD_BIT_COUNT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_RESET_BY_TAG    = 3'd4;
  localparam logic [IDX_W-1:0] REG_RESET_PERIOD    = 3'd5;

  // Feedback bit: parity of the register under the tap mask.
  function automatic logic feedback_bit(input logic [LFSR_W-1:0] sr,
                                        input logic [LFSR_W-1:0] mask);
    feedback_bit = ^(sr & mask);
  endfunction

endpackage

@@ src/additive_lfsr_byte_scrambler_top.sv @@
`timescale 1ns / 1ps
// Top level of the additive LFSR byte scrambler: input register, LFSR pad
// logic, result register and APB register file. Depends on albs_pkg.
//
// Usage:
// - Input channel (in_valid, in_stall, data_in, reset_mark) carries one byte
//   per item. An item is taken at a clock edge with in_valid high and
//   in_stall low.
// - Output channel (out_valid, out_stall, data_out) returns one scrambled
//   byte per item, in order.
// - An item passes through the input register and then the result register.
//   Throughput is one item per clock while the receiver does not stall; each
//   byte's pad comes from up to eight unrolled LFSR steps in the single stage.
// - The LFSR and byte counter advance when an item moves from the input
//   register into the result register.
// - When the receiver stalls, the result register holds; the input register
//   still fills, and in_stall rises only when both registers hold items.
// - Synchronous reset (rst) empties both registers, clears the LFSR and the
//   byte counter, and returns the configuration registers to their defaults.
// - Configuration is written over APB at byte address 4*index while no item
//   is in flight; a seed write takes effect at the next reset event.
module additive_lfsr_byte_scrambler_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [albs_pkg::DATA_W-1:0]    data_in,
  input  logic                           reset_mark,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [albs_pkg::DATA_W-1:0]    data_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [albs_pkg::ADDR_W-1:0]    paddr,
  input  logic [albs_pkg::APB_W-1:0]     pwdata,
  output logic [albs_pkg::APB_W-1:0]     prdata,
  output logic                           pready
);
  import albs_pkg::*;

  // Configuration registers.
  logic [LFSR_W-1:0] feedback_mask;
  logic [LFSR_W-1:0] seed_value;
  logic [POS_W-1:0]  insert_position;
  logic [BPB_W-1:0]  pad_bit_count;
  logic              reset_by_tag;
  logic [CNT_W-1:0]  reset_period;

  // Scrambler state.
  logic [LFSR_W-1:0] shift_reg;
  logic [LFSR_W-1:0] shift_reg_next;
  logic [CNT_W-1:0]  byte_counter;
  logic [CNT_W-1:0]  byte_counter_next;

  // Input register and result register.
  logic              s1_valid;
  logic [DATA_W-1:0] s1_data;
  logic              s1_mark;
  logic [DATA_W-1:0] pad;
  logic [DATA_W-1:0] data_out_next;

  logic [IDX_W-1:0]  reg_idx;
  logic              cfg_write;
  logic              s1_advance;
  logic              in_accept;
  logic              do_reset;
  logic [BPB_W-1:0]  steps;

  assign reg_idx    = paddr[ADDR_W-1:2];
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_mask   <= '0;
      seed_value      <= '0;
      insert_position <= '0;
      pad_bit_count   <= BPB_W'(1);
      reset_by_tag    <= 1'b0;
      reset_period    <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FEEDBACK_MASK:   feedback_mask   <= pwdata[LFSR_W-1:0];
        REG_SEED_VALUE:      seed_value      <= pwdata[LFSR_W-1:0];
        REG_INSERT_POSITION: insert_position <= pwdata[POS_W-1:0];
        REG_PAD_BIT_COUNT:   pad_bit_count   <= pwdata[BPB_W-1:0];
        REG_RESET_BY_TAG:    reset_by_tag    <= pwdata[0];
        REG_RESET_PERIOD:    reset_period    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FEEDBACK_MASK:   prdata = feedback_mask;
      REG_SEED_VALUE:      prdata = seed_value;
      REG_INSERT_POSITION: prdata = APB_W'(insert_position);
      REG_PAD_BIT_COUNT:   prdata = APB_W'(pad_bit_count);
      REG_RESET_BY_TAG:    prdata = APB_W'(reset_by_tag);
      REG_RESET_PERIOD:    prdata = APB_W'(reset_period);
      default:             prdata = '0;
    endcase
  end

  // Pad logic for the item in the input register.
  always_comb begin
    logic [LFSR_W-1:0] sr;
    logic [CNT_W-1:0]  cnt;
    logic              fb;
    if (reset_by_tag) begin
      do_reset = s1_mark;
    end else begin
      do_reset = (reset_period != '0) && (reset_period == byte_counter);
    end
    steps = (pad_bit_count > BPB_W'(MAX_STEPS)) ? BPB_W'(MAX_STEPS) : pad_bit_count;
    sr    = do_reset ? seed_value : shift_reg;
    cnt   = do_reset ? '0 : byte_counter;
    pad   = '0;
    fb    = 1'b0;
    for (int k = 0; k < MAX_STEPS; k++) begin
      if (BPB_W'(k) < steps) begin
        fb     = feedback_bit(sr, feedback_mask);
        sr     = (sr >> 1) | (LFSR_W'(fb) << insert_position);
        pad[k] = fb;
      end
    end
    shift_reg_next    = sr;
    byte_counter_next = (cnt < COUNTER_MAX) ? cnt + CNT_W'(1) : cnt;
    data_out_next     = s1_data ^ pad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      shift_reg    <= '0;
      byte_counter <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid    <= 1'b1;
        shift_reg    <= shift_reg_next;
        byte_counter <= byte_counter_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= data_in;
      s1_mark <= reset_mark;
    end
    if (s1_advance) begin
      data_out <= data_out_next;
    end
  end

endmodule

@@ bench/tb_additive_lfsr_byte_scrambler_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for additive_lfsr_byte_scrambler_top: a scoreboard
// class predicts every scrambled byte while tasks drive items and APB writes.
// Depends on albs_pkg and the scrambler RTL.
module tb_additive_lfsr_byte_scrambler_top;
  import albs_pkg::*;

  class scramble_scoreboard;
    logic [LFSR_W-1:0] tap_mask;
    logic [LFSR_W-1:0] seed;
    logic [LFSR_W-1:0] lfsr;
    logic [POS_W-1:0]  insert_pos;
    logic [BPB_W-1:0]  steps_cfg;
    logic              tag_mode;
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  byte_count;
    logic [DATA_W-1:0] expected_bytes[$];
    int                errors;

    function new();
      tap_mask   = '0;
      seed       = '0;
      lfsr       = '0;
      insert_pos = '0;
      steps_cfg  = BPB_W'(1);
      tag_mode   = 1'b0;
      period     = '0;
      byte_count = '0;
      errors     = 0;
    endfunction

    // A seed write only changes what the next reload uses.
    function void write_reg(logic [IDX_W-1:0] idx, logic [APB_W-1:0] value);
      case (idx)
        REG_FEEDBACK_MASK:   tap_mask = value;
        REG_SEED_VALUE:      seed = value;
        REG_INSERT_POSITION: insert_pos = value[POS_W-1:0];
        REG_PAD_BIT_COUNT:   steps_cfg = value[BPB_W-1:0];
        REG_RESET_BY_TAG:    tag_mode = value[0];
        REG_RESET_PERIOD:    period = value[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [DATA_W-1:0] data, logic mark);
      int                n;
      logic              fb;
      logic              reload;
      logic [DATA_W-1:0] pad;
      n = (steps_cfg > MAX_STEPS) ? MAX_STEPS : int'(steps_cfg);
      reload = tag_mode ? mark : (period != 0 && period == byte_count);
      if (reload) begin
        lfsr = seed;
        byte_count = '0;
      end
      pad = '0;
      for (int k = 0; k < n; k++) begin
        fb = ^(lfsr & tap_mask);
        lfsr = (lfsr >> 1) | ({{(LFSR_W-1){1'b0}}, fb} << insert_pos);
        pad[k] = fb;
      end
      expected_bytes.push_back(data ^ pad);
      if (byte_count != COUNTER_MAX) byte_count++;
    endfunction

    function void check_byte(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: data_out with no item pending, expected none, actual %02h",
                 $time, actual);
        return;
      end
      want = expected_bytes.pop_front();
      if (actual !== want) begin
        errors++;
        $display("%0t: data_out mismatch, expected %02h, actual %02h", $time, want, actual);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [DATA_W-1:0]   data_in;
  logic                reset_mark;
  logic                out_valid;
  logic                out_stall;
  logic [DATA_W-1:0]   data_out;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [APB_W-1:0]    pwdata;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  scramble_scoreboard  sb;
  bit                  hold_request;

  additive_lfsr_byte_scrambler_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_in    (data_in),
    .reset_mark (reset_mark),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin : watchdog
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_byte(data_out);
  end

  // The receiver switches between stall patterns on its own schedule. A hold
  // request makes it refuse results long enough to back the block up.
  initial begin : receiver
    int style;
    int style_left;
    int hold_left;
    logic stall_next;
    style = 0;
    style_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 60;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 60);
      end
      style_left--;
      case (style)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = ~out_stall;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  // APB write with a setup phase and an access phase, then an idle wait, so
  // back-to-back calls never assign the same signal twice at one edge.
  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [APB_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input logic [DATA_W-1:0] d, input logic m);
    in_valid   <= 1'b1;
    data_in    <= d;
    reset_mark <= m;
    do @(posedge clk); while (in_stall);
    sb.take_byte(d, m);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Configuration may only change once every pending byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_config();
    logic [APB_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    apb_write(REG_FEEDBACK_MASK, v);
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    apb_write(REG_SEED_VALUE, v);
    case ($urandom_range(0, 3))
      0: v = 0;
      1: v = 31;
      default: v = $urandom_range(0, 31);
    endcase
    apb_write(REG_INSERT_POSITION, v);
    v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    apb_write(REG_PAD_BIT_COUNT, v);
    apb_write(REG_RESET_BY_TAG, $urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 1;
      2: v = APB_W'(COUNTER_MAX);
      3: v = $urandom_range(0, 32'h00FF_FFFF);
      default: v = $urandom_range(2, 12);
    endcase
    apb_write(REG_RESET_PERIOD, v);
  endtask

  // Tags are kept rare in tag mode so the register runs for a while between
  // reloads; in count mode the mark is ignored and toggles freely.
  task automatic run_random(input int count, input bit gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && sent < count) begin
        send_item($urandom_range(0, 255),
                  sb.tag_mode ? ($urandom_range(0, 9) == 0) : $urandom_range(0, 1));
        burst--;
        sent++;
      end
      if (gaps && sent < count && $urandom_range(0, 3) != 0)
        idle_sender($urandom_range(1, 6));
    end
  endtask

  initial begin : stimulus
    sb = new();
    hold_request = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_in    = '0;
    reset_mark = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults: no taps, so bytes pass through unchanged.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b1);
    drain();

    // Tag mode; the new seed must not show until the first tagged byte, and
    // the period is ignored while the counter runs past it.
    apb_write(REG_FEEDBACK_MASK, 32'hA300_0001);
    apb_write(REG_SEED_VALUE, 32'hFFFF_FFFF);
    apb_write(REG_INSERT_POSITION, 31);
    apb_write(REG_PAD_BIT_COUNT, 8);
    apb_write(REG_RESET_BY_TAG, 1);
    apb_write(REG_RESET_PERIOD, 5);
    send_item(8'h3C, 1'b0);
    send_item(8'hC3, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    drain();

    // Count mode with zero steps: marks are ignored and the pad is empty.
    apb_write(REG_RESET_BY_TAG, 0);
    apb_write(REG_RESET_PERIOD, 3);
    apb_write(REG_PAD_BIT_COUNT, 0);
    send_item(8'h11, 1'b1);
    send_item(8'h22, 1'b0);
    send_item(8'h33, 1'b1);
    send_item(8'h44, 1'b0);
    drain();

    // Step count above eight saturates; all taps, insert at bit zero.
    apb_write(REG_PAD_BIT_COUNT, 15);
    apb_write(REG_INSERT_POSITION, 0);
    apb_write(REG_FEEDBACK_MASK, 32'hFFFF_FFFF);
    apb_write(REG_SEED_VALUE, 32'h0000_0001);
    for (int i = 0; i < 6; i++) send_item(8'hF0 ^ i[7:0], i[0]);

    for (int phase = 0; phase < 9; phase++) begin
      drain();
      random_config();
      if (phase == 3) hold_request = 1'b1;
      run_random(50, phase != 3 && phase != 6);
    end

    drain();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/albs_pkg.sv
src/additive_lfsr_byte_scrambler_top.sv
bench/tb_additive_lfsr_byte_scrambler_top.sv
